// File: hw/rtl/platform_interrupt_controller_top_macros.svh
// Assertion macros for the interrupt controller top level.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef PLATFORM_INTERRUPT_CONTROLLER_TOP_MACROS_SVH
`define PLATFORM_INTERRUPT_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PLIC_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PLIC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/plic_pkg.sv
// Shared types, command codes and register map of the interrupt controller.
// No dependencies.
package plic_pkg;

    localparam int NUM_SOURCES_DEF   = 32;
    localparam int PRIORITY_BITS_DEF = 3;

    localparam int CMD_W  = 2;
    localparam int ADDR_W = 26;
    localparam int DATA_W = 32;
    localparam int LINE_W = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_NONE  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2
    } plic_cmd_t;

    localparam logic [ADDR_W-1:0] PEND_BASE   = 26'h000_1000;
    localparam logic [ADDR_W-1:0] MEN_BASE    = 26'h000_2000;
    localparam logic [ADDR_W-1:0] SEN_BASE    = 26'h000_2080;
    localparam logic [ADDR_W-1:0] MTHR_ADDR   = 26'h020_0000;
    localparam logic [ADDR_W-1:0] MCLAIM_ADDR = 26'h020_0004;
    localparam logic [ADDR_W-1:0] STHR_ADDR   = 26'h020_1000;
    localparam logic [ADDR_W-1:0] SCLAIM_ADDR = 26'h020_1004;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
        logic [LINE_W-1:0] irq_lines;
    } plic_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              machine_irq;
        logic              supervisor_irq;
        logic              bad_access;
    } plic_rsp_t;

endpackage

// File: hw/rtl/plic_if.sv
// Valid/ready channel interfaces for request and response beats.
// Depends on plic_pkg.
interface plic_req_if;
    import plic_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
    logic [LINE_W-1:0] irq_lines;

    modport source (output valid, command, address, write_data, irq_lines, input ready);
    modport sink   (input valid, command, address, write_data, irq_lines, output ready);
endinterface

interface plic_rsp_if;
    import plic_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              machine_irq;
    logic              supervisor_irq;
    logic              bad_access;

    modport source (output valid, read_data, machine_irq, supervisor_irq, bad_access,
                    input ready);
    modport sink   (input valid, read_data, machine_irq, supervisor_irq, bad_access,
                    output ready);
endinterface

// File: hw/rtl/plic_select.sv
// Priority select tree: highest priority above threshold, lowest id on ties.
// Depends on nothing but its parameters.
module plic_select #(
    parameter int NUM_SOURCES   = 32,
    parameter int PRIORITY_BITS = 3
) (
    input  logic [NUM_SOURCES-1:0]         cand,
    input  logic [PRIORITY_BITS-1:0]       prio [NUM_SOURCES],
    input  logic [PRIORITY_BITS-1:0]       thr,
    output logic [$clog2(NUM_SOURCES)-1:0] id,
    output logic                           found
);
    localparam int IDW = $clog2(NUM_SOURCES);
    localparam int P   = 1 << IDW;

    logic                     nv [1:2*P-1];
    logic [PRIORITY_BITS-1:0] np [1:2*P-1];
    logic [IDW-1:0]           ni [1:2*P-1];

    for (genvar g = 0; g < P; g++) begin : g_leaf
        if (g < NUM_SOURCES) begin : g_real
            assign nv[P+g] = cand[g] && (prio[g] > thr);
            assign np[P+g] = prio[g];
        end
        else begin : g_pad
            assign nv[P+g] = 1'b0;
            assign np[P+g] = '0;
        end
        assign ni[P+g] = IDW'(g);
    end

    for (genvar n = 1; n < P; n++) begin : g_node
        logic take_r;
        assign take_r = nv[2*n+1] && (!nv[2*n] || (np[2*n+1] > np[2*n]));
        assign nv[n]  = nv[2*n] || nv[2*n+1];
        assign np[n]  = take_r ? np[2*n+1] : np[2*n];
        assign ni[n]  = take_r ? ni[2*n+1] : ni[2*n];
    end

    assign id    = ni[1];
    assign found = nv[1];
endmodule

// File: hw/rtl/plic_regs.sv
// Controller state, gateways, register decode, claim and complete.
// Depends on plic_pkg and plic_select.
module plic_regs #(
    parameter int NUM_SOURCES   = plic_pkg::NUM_SOURCES_DEF,
    parameter int PRIORITY_BITS = plic_pkg::PRIORITY_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  plic_pkg::plic_req_t item,
    input  logic                fire,
    output plic_pkg::plic_rsp_t result
);
    import plic_pkg::*;

    localparam int IDW = $clog2(NUM_SOURCES);
    localparam int EW  = (NUM_SOURCES + 31) / 32;
    localparam logic [ADDR_W-1:0] PRIO_END = 26'(4 * NUM_SOURCES);
    localparam logic [ADDR_W-1:0] PEND_END = PEND_BASE + 26'(4 * EW);
    localparam logic [ADDR_W-1:0] MEN_END  = MEN_BASE + 26'(4 * EW);
    localparam logic [ADDR_W-1:0] SEN_END  = SEN_BASE + 26'(4 * EW);

    logic [PRIORITY_BITS-1:0] prio_reg [NUM_SOURCES];
    logic [NUM_SOURCES-1:0]   pend_reg, insvc_reg, men_reg, sen_reg;
    logic [PRIORITY_BITS-1:0] mthr_reg, sthr_reg;

    logic [NUM_SOURCES-1:0]   pend_next, insvc_next, men_next, sen_next;
    logic [PRIORITY_BITS-1:0] mthr_next, sthr_next;

    logic [NUM_SOURCES-1:0]   mask, lines_n, pend_g, ctx_en, claim_vec, compl_vec;
    logic [63:0]              lines64, pend64, men64, sen64, fld64, wdat64, men_w64, sen_w64;
    logic [PRIORITY_BITS-1:0] ctx_thr;
    logic [IDW-1:0]           prio_idx, claim_id;
    logic                     claim_any, m_any, s_any;
    logic                     aligned, is_rd, is_wr, wsel, sup;
    logic                     hit_prio, hit_pend, hit_men, hit_sen;
    logic                     hit_mthr, hit_sthr, hit_claim, mapped, claim_go, cmp_go;
    logic [DATA_W-1:0]        rdata;

    assign mask    = {{(NUM_SOURCES-1){1'b1}}, 1'b0};
    assign lines64 = {32'h0, item.irq_lines};
    assign lines_n = lines64[NUM_SOURCES-1:0];
    assign pend_g  = pend_reg | (lines_n & ~insvc_reg & mask);

    assign aligned   = (item.address[1:0] == 2'b00);
    assign is_rd     = (item.command == CMD_READ);
    assign is_wr     = (item.command == CMD_WRITE);
    assign wsel      = item.address[2];
    assign prio_idx  = item.address[IDW+1:2];
    assign hit_prio  = aligned && (item.address < PRIO_END);
    assign hit_pend  = aligned && (item.address >= PEND_BASE) && (item.address < PEND_END);
    assign hit_men   = aligned && (item.address >= MEN_BASE) && (item.address < MEN_END);
    assign hit_sen   = aligned && (item.address >= SEN_BASE) && (item.address < SEN_END);
    assign hit_mthr  = (item.address == MTHR_ADDR);
    assign hit_sthr  = (item.address == STHR_ADDR);
    assign hit_claim = (item.address == MCLAIM_ADDR) || (item.address == SCLAIM_ADDR);
    assign mapped    = hit_prio || hit_pend || hit_men || hit_sen || hit_mthr || hit_sthr
                       || hit_claim;

    assign sup     = (item.address == SCLAIM_ADDR);
    assign ctx_en  = sup ? sen_reg : men_reg;
    assign ctx_thr = sup ? sthr_reg : mthr_reg;

    plic_select #(
        .NUM_SOURCES  (NUM_SOURCES),
        .PRIORITY_BITS(PRIORITY_BITS)
    ) u_claim_sel (
        .cand (pend_g & ctx_en & mask),
        .prio (prio_reg),
        .thr  (ctx_thr),
        .id   (claim_id),
        .found(claim_any)
    );

    plic_select #(
        .NUM_SOURCES  (NUM_SOURCES),
        .PRIORITY_BITS(PRIORITY_BITS)
    ) u_m_sel (
        .cand (pend_reg & men_reg & mask),
        .prio (prio_reg),
        .thr  (mthr_reg),
        .id   (),
        .found(m_any)
    );

    plic_select #(
        .NUM_SOURCES  (NUM_SOURCES),
        .PRIORITY_BITS(PRIORITY_BITS)
    ) u_s_sel (
        .cand (pend_reg & sen_reg & mask),
        .prio (prio_reg),
        .thr  (sthr_reg),
        .id   (),
        .found(s_any)
    );

    assign claim_go = is_rd && hit_claim && claim_any;
    assign cmp_go   = is_wr && hit_claim;

    always_comb
    begin
        for (int s = 0; s < NUM_SOURCES; s++)
        begin
            claim_vec[s] = claim_go && (claim_id == IDW'(s));
            compl_vec[s] = cmp_go && mask[s] && ctx_en[s] && (item.write_data == 32'(s));
        end
    end

    assign pend64  = 64'(pend_g);
    assign men64   = 64'(men_reg);
    assign sen64   = 64'(sen_reg);
    assign fld64   = wsel ? {32'hFFFF_FFFF, 32'h0} : {32'h0, 32'hFFFF_FFFF};
    assign wdat64  = wsel ? {item.write_data, 32'h0} : {32'h0, item.write_data};
    assign men_w64 = (men64 & ~fld64) | (wdat64 & fld64);
    assign sen_w64 = (sen64 & ~fld64) | (wdat64 & fld64);

    always_comb
    begin
        rdata = '0;
        if (is_rd)
        begin
            if (hit_prio)
                rdata = 32'(prio_reg[prio_idx]);
            else if (hit_pend)
                rdata = wsel ? pend64[63:32] : pend64[31:0];
            else if (hit_men)
                rdata = wsel ? men64[63:32] : men64[31:0];
            else if (hit_sen)
                rdata = wsel ? sen64[63:32] : sen64[31:0];
            else if (hit_mthr)
                rdata = 32'(mthr_reg);
            else if (hit_sthr)
                rdata = 32'(sthr_reg);
            else if (claim_go)
                rdata = 32'(claim_id);
        end
    end

    assign pend_next  = pend_g & ~claim_vec;
    assign insvc_next = (insvc_reg | claim_vec) & ~compl_vec;
    assign men_next   = (is_wr && hit_men) ? (men_w64[NUM_SOURCES-1:0] & mask) : men_reg;
    assign sen_next   = (is_wr && hit_sen) ? (sen_w64[NUM_SOURCES-1:0] & mask) : sen_reg;
    assign mthr_next  = (is_wr && hit_mthr) ? item.write_data[PRIORITY_BITS-1:0] : mthr_reg;
    assign sthr_next  = (is_wr && hit_sthr) ? item.write_data[PRIORITY_BITS-1:0] : sthr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SOURCES; s++)
                prio_reg[s] <= '0;
            pend_reg  <= '0;
            insvc_reg <= '0;
            men_reg   <= '0;
            sen_reg   <= '0;
            mthr_reg  <= '0;
            sthr_reg  <= '0;
        end
        else if (fire)
        begin
            for (int s = 1; s < NUM_SOURCES; s++)
            begin
                if (is_wr && hit_prio && (prio_idx == IDW'(s)))
                    prio_reg[s] <= item.write_data[PRIORITY_BITS-1:0];
            end
            pend_reg  <= pend_next;
            insvc_reg <= insvc_next;
            men_reg   <= men_next;
            sen_reg   <= sen_next;
            mthr_reg  <= mthr_next;
            sthr_reg  <= sthr_next;
        end
    end

    assign result.read_data      = rdata;
    assign result.machine_irq    = m_any;
    assign result.supervisor_irq = s_any;
    assign result.bad_access     = (is_rd || is_wr) && !mapped;
endmodule

// File: hw/rtl/platform_interrupt_controller_top.sv
// Channel  | Dir | Beat
// ---------+-----+-------------------------------------------------
// req      | in  | command, address, write_data, irq_lines
// rsp      | out | read_data, machine_irq, supervisor_irq, bad_access
//
// One beat per cycle sustained while rsp is ready; each beat passes the input register
// then the result register, with state updated as the beat enters the result register.
// The select tree and register decode between the two registers set the cycle.
// Reset clears all state and both stages; rsp stalls hold the result and back
// up into the input register, then into req.ready.
// Depends on plic_pkg, plic_if, plic_regs and the macros header.
`include "platform_interrupt_controller_top_macros.svh"

module platform_interrupt_controller_top #(
    parameter int NUM_SOURCES   = plic_pkg::NUM_SOURCES_DEF,
    parameter int PRIORITY_BITS = plic_pkg::PRIORITY_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    plic_req_if.sink   req,
    plic_rsp_if.source rsp
);
    import plic_pkg::*;

    logic              s1_valid_reg, s1_valid_next;
    plic_req_t         s1_item_reg;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_data_reg;
    logic              out_bad_reg;
    logic              res_load, s1_adv, req_take;
    plic_rsp_t         result;

    assign res_load       = !out_valid_reg || rsp.ready;
    assign s1_adv         = s1_valid_reg && res_load;
    assign req.ready      = !s1_valid_reg || s1_adv;
    assign req_take       = req.valid && req.ready;
    assign s1_valid_next  = req_take || (s1_valid_reg && !s1_adv);
    assign out_valid_next = s1_adv || (out_valid_reg && !rsp.ready);

    plic_regs #(
        .NUM_SOURCES  (NUM_SOURCES),
        .PRIORITY_BITS(PRIORITY_BITS)
    ) u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (s1_item_reg),
        .fire  (s1_adv),
        .result(result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // capture the request beat
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            s1_item_reg.command    <= req.command;
            s1_item_reg.address    <= req.address;
            s1_item_reg.write_data <= req.write_data;
            s1_item_reg.irq_lines  <= req.irq_lines;
        end
    end

    // hold the result until taken
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_data_reg <= result.read_data;
            out_bad_reg  <= result.bad_access;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.read_data      = out_data_reg;
    assign rsp.bad_access     = out_bad_reg;
    assign rsp.machine_irq    = result.machine_irq;
    assign rsp.supervisor_irq = result.supervisor_irq;

    `PLIC_ASSERT_NEXT(a_take_fills_stage, req_take, s1_valid_reg, "accepted beat lost")
    `PLIC_ASSERT_NEXT(a_stall_keeps_both, out_valid_reg && !rsp.ready && s1_valid_reg, s1_valid_reg && out_valid_reg, "beat dropped under stall")
    `PLIC_ASSERT_IMPLY(a_bad_reads_zero, rsp.valid && rsp.bad_access, rsp.read_data == '0, "unmapped access returned data")
endmodule
